FILE: hw/rtl/scfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, constants and helpers of the serial command frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W       = IDX_W + 1;
  localparam int MEM_DEPTH    = 2 ** ADDR_W;

  localparam int HEADER_LEN   = 9;
  localparam int HDR_IW       = $clog2(HEADER_LEN);
  localparam int MIN_LEN      = 13;
  localparam int HIST_LEN     = 4;
  localparam int JOBQ_DEPTH   = 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [7:0]  START_BYTE    = 8'hFE;
  localparam logic [15:0] RESERVED_WORD = 16'h0000;
  localparam logic [7:0]  DIR_DOWN      = 8'hF0;
  localparam logic [7:0]  END_BYTE0     = 8'hF1;
  localparam logic [7:0]  END_BYTE1     = 8'h1F;
  localparam logic [7:0]  END_BYTE2     = 8'hF2;
  localparam logic [1:0]  END_LEN       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PROTOCOL  = 3'd1,
    ST_RESERVED  = 3'd2,
    ST_DEVICE    = 3'd3,
    ST_DIRECTION = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_SHORT     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       mode;
    logic [7:0]       command;
    logic [CNT_W-1:0] n;
    logic             bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  function automatic logic [7:0] end_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = END_BYTE0;
      2'd1:    val = END_BYTE1;
      default: val = END_BYTE2;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/scfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_if
// Word channels of the receiver: input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface scfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] mode;
  logic [7:0] command;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       last;
  modport source (output valid, output status, output mode, output command,
                  output payload_byte, output payload_valid, output last,
                  input ready);
  modport sink   (input valid, input status, input mode, input command,
                  input payload_byte, input payload_valid, input last,
                  output ready);
endinterface

interface scfr_cfg_if import scfr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [15:0]          wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/serial_command_frame_receiver.sv
// Timing: with the back idle, a finished frame is first registered in the frame queue,
// then the back moves to send; a payload result also passes the fetch state first.
// Throughput: one input byte per cycle while the frame queue has room; every
// payload result waits in the fetch state for the registered read of the store.
// Reset: synchronous, active low; clears control state, the frame queue and the
// registers, and leaves the byte store undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Top level: register file, front, frame queue, byte store and back.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver
  import scfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  scfr_in_if.sink     in_if,
  scfr_out_if.source  out_if,
  scfr_cfg_if.sink    cfg_if
);

  logic [15:0] protocol_id_r;
  logic [15:0] device_id_r;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  job_t        q_job;
  job_t        q_head;
  mem_wr_t     mem_wr;
  mem_rd_t     mem_rd;
  logic [7:0]  rd_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_id_r <= 16'd1;
      device_id_r   <= 16'd1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.reg_index)
        REG_PROTOCOL_ID: protocol_id_r <= cfg_if.wdata;
        REG_DEVICE_ID:   device_id_r   <= cfg_if.wdata;
        default: begin
        end
      endcase
    end
  end

  scfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .protocol_id (protocol_id_r),
    .device_id   (device_id_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job),
    .mem_wr      (mem_wr)
  );

  scfr_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .job_in (q_job),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  scfr_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  scfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .mem_rd  (mem_rd),
    .rd_data (rd_data),
    .out_if  (out_if)
  );

`ifndef SYNTHESIS
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status != ST_OK) |->
      out_if.last && !out_if.payload_valid && (out_if.mode == 8'd0) &&
      (out_if.command == 8'd0))
    else $error("error result is not a single bare word");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.payload_valid |-> out_if.last)
    else $error("word without payload is not the last of its frame");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && out_if.last |=> !out_if.valid)
    else $error("result follows the last word of a frame without a gap");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/scfr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_store
// Two-bank frame byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module scfr_store
  import scfr_pkg::*;
(
  input  wire logic       clk,
  input  wire mem_wr_t    wr,
  input  wire mem_rd_t    rd,
  output logic [7:0]      rd_data
);

  logic [7:0] mem_r [MEM_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/scfr_jobq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_jobq
// Two-entry queue of checked frames between the front and the back.
// ----------------------------------------------------------------------------
module scfr_jobq
  import scfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t job_in,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  job_t       mem_r [JOBQ_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(JOBQ_DEPTH));

endmodule
`default_nettype wire

FILE: hw/rtl/scfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_front
// Frame hunting, byte buffering, end detection and frame checking.
// ----------------------------------------------------------------------------
module scfr_front
  import scfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  scfr_in_if.sink          in_if,
  input  wire logic [15:0] protocol_id,
  input  wire logic [15:0] device_id,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job,
  output mem_wr_t          mem_wr
);

  logic             in_frame_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       em_r;
  logic [7:0]       sum_r;
  logic             bank_r;
  logic [7:0]       hist_r [HIST_LEN];
  logic [7:0]       hdr_r  [HEADER_LEN];

  logic             acc;
  logic [7:0]       b;
  logic             store;
  logic             start;
  logic             drop;
  logic [1:0]       em_nxt;
  logic [7:0]       sum_nxt;
  logic             done;
  status_t          status;

  assign in_if.ready = !q_full;
  assign acc   = in_if.valid && in_if.ready;
  assign b     = in_if.rx_byte;
  assign start = acc && !in_frame_r && (b == START_BYTE);
  assign drop  = acc && in_frame_r && (cnt_r == CNT_W'(BUFFER_DEPTH));
  assign store = acc && in_frame_r && (cnt_r != CNT_W'(BUFFER_DEPTH));

  always_comb begin
    if (b == end_byte(em_r)) begin
      em_nxt = em_r + 2'd1;
    end else if (b == END_BYTE0) begin
      em_nxt = 2'd1;
    end else begin
      em_nxt = 2'd0;
    end
  end

  // The running sum lags four bytes behind, so at the last end byte it covers
  // exactly the bytes before the checksum.
  assign sum_nxt = sum_r + ((cnt_r >= CNT_W'(HIST_LEN)) ? hist_r[HIST_LEN-1] : 8'd0);
  assign done    = store && (em_nxt == END_LEN);

  always_comb begin
    if (cnt_r < CNT_W'(MIN_LEN - 1)) begin
      status = ST_SHORT;
    end else if ({hdr_r[0], hdr_r[1]} != protocol_id) begin
      status = ST_PROTOCOL;
    end else if ({hdr_r[2], hdr_r[3]} != RESERVED_WORD) begin
      status = ST_RESERVED;
    end else if ({hdr_r[4], hdr_r[5]} != device_id) begin
      status = ST_DEVICE;
    end else if (hdr_r[6] != DIR_DOWN) begin
      status = ST_DIRECTION;
    end else if (sum_nxt != hist_r[HIST_LEN-2]) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    q_push        = done;
    q_job.status  = status;
    q_job.mode    = (status == ST_OK) ? hdr_r[7] : 8'd0;
    q_job.command = (status == ST_OK) ? hdr_r[8] : 8'd0;
    q_job.n       = (status == ST_OK) ? (cnt_r - CNT_W'(MIN_LEN - 1)) : '0;
    q_job.bank    = bank_r;
    mem_wr.en     = store;
    mem_wr.addr   = {bank_r, cnt_r[IDX_W-1:0]};
    mem_wr.data   = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      em_r       <= 2'd0;
      sum_r      <= 8'd0;
      bank_r     <= 1'b0;
    end else if (start) begin
      in_frame_r <= 1'b1;
      cnt_r      <= '0;
      em_r       <= 2'd0;
      sum_r      <= 8'd0;
    end else if (drop || done) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      em_r       <= 2'd0;
      if (done) begin
        bank_r <= ~bank_r;
      end
    end else if (store) begin
      cnt_r <= cnt_r + CNT_W'(1);
      em_r  <= em_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      hist_r[0] <= b;
      for (int i = 1; i < HIST_LEN; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      if (cnt_r < CNT_W'(HEADER_LEN)) begin
        hdr_r[cnt_r[HDR_IW-1:0]] <= b;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/scfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_back
// Result sequencer: reads payload bytes of a checked frame and sends results.
// ----------------------------------------------------------------------------
module scfr_back
  import scfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output mem_rd_t         mem_rd,
  input  wire logic [7:0] rd_data,
  scfr_out_if.source      out_if
);

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_pos;
  logic             single;
  logic             is_last;

  assign single  = (head.status != ST_OK) || (head.n == '0);
  assign is_last = single || (CNT_W'(idx_r + CNT_W'(1)) == head.n);
  assign rd_pos  = CNT_W'(HEADER_LEN) + rd_idx;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = single ? BK_SEND : BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (out_if.ready) begin
          state_nxt = is_last ? BK_IDLE : BK_FETCH;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_rd.en = 1'b0;
    rd_idx    = idx_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
        rd_idx  = '0;
        if (!q_empty && !single) begin
          mem_rd.en = 1'b1;
        end
      end
      BK_FETCH: begin
      end
      BK_SEND: begin
        if (out_if.ready) begin
          if (is_last) begin
            q_pop = 1'b1;
          end else begin
            rd_idx    = idx_r + CNT_W'(1);
            idx_nxt   = rd_idx;
            mem_rd.en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    mem_rd.addr = {head.bank, rd_pos[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_if.valid         = (state_r == BK_SEND);
  assign out_if.status        = head.status;
  assign out_if.mode          = head.mode;
  assign out_if.command       = head.command;
  assign out_if.payload_valid = !single;
  assign out_if.payload_byte  = single ? 8'd0 : rd_data;
  assign out_if.last          = is_last;

endmodule
`default_nettype wire

FILE: tb/sv/serial_command_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_tb
// Self-checking bench for the serial command frame receiver. A table of
// directed frames covers header errors, short frames, overflow, odd trailer
// patterns and register extremes, and random frames follow in phases with
// different register settings. Both channels idle at random; each result is
// matched to a bit-exact frame predictor in the bench or, for some directed rows, a typed one.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_tb;
  import scfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
  localparam logic [7:0] DIR_UP        = 8'h0F;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         MAX_REPORTS   = 10;

  typedef struct packed {
    status_t    status;
    logic [7:0] mode;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;
  } frame_result_t;

  typedef enum {ROW_FRAME, ROW_TRICKY, ROW_SHORT, ROW_OPEN, ROW_CFG} row_kind_t;
  typedef enum {CHK_MODEL, CHK_ONE, CHK_NONE} row_check_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]          cfg_val;
    logic [15:0]          proto;
    logic [15:0]          rsvd;
    logic [15:0]          dev;
    logic [7:0]           dir;
    logic [7:0]           mode;
    logic [7:0]           cmd;
    int                   npay;
    logic [7:0]           pbase;
    logic [7:0]           pstep;
    int                   ckd;
    int                   lead;
    bit                   scramble;
    row_check_t           chk;
    status_t              st;
  } stim_row_t;

  logic clk;
  logic rst_n;

  scfr_in_if  in_if ();
  scfr_out_if out_if ();
  scfr_cfg_if cfg_if ();

  serial_command_frame_receiver u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  logic [7:0]    rx_store [BUFFER_DEPTH];
  int            rx_count;
  bit            rx_in_frame;
  int            rx_hits;
  logic [15:0]   cfg_protocol;
  logic [15:0]   cfg_device;

  frame_result_t fresh_results_q [$];
  frame_result_t frame_results_q [$];
  logic [7:0]    tx_bytes [$];
  stim_row_t     plan [$];

  bit hold_results;
  bit src_steady;
  int sink_hold;
  int data_bytes;
  int results_posted;
  int fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic string show(input frame_result_t v);
    return $sformatf("st=%0d mode=%02h cmd=%02h pb=%02h pv=%0b last=%0b",
                     v.status, v.mode, v.command, v.payload_byte, v.payload_valid, v.last);
  endfunction

  function void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [7:0] trailer_byte(input int pos);
    case (pos)
      0:       return END_BYTE0;
      1:       return END_BYTE1;
      default: return END_BYTE2;
    endcase
  endfunction

  function automatic status_t judge_frame(input int len);
    int         ck_at;
    logic [7:0] sum;
    if (len < MIN_LEN) return ST_SHORT;
    if ({rx_store[0], rx_store[1]} != cfg_protocol) return ST_PROTOCOL;
    if ({rx_store[2], rx_store[3]} != RESERVED_WORD) return ST_RESERVED;
    if ({rx_store[4], rx_store[5]} != cfg_device) return ST_DEVICE;
    if (rx_store[6] != DIR_DOWN) return ST_DIRECTION;
    ck_at = len - int'(END_LEN) - 1;
    sum = 8'h00;
    for (int i = 0; i < ck_at; i++) sum = sum + rx_store[i];
    if (sum != rx_store[ck_at]) return ST_CHECKSUM;
    return ST_OK;
  endfunction

  function void absorb_rx_byte(input logic [7:0] b);
    int            len;
    int            n;
    status_t       st;
    frame_result_t res;
    if (!rx_in_frame) begin
      if (b == START_BYTE) begin
        rx_in_frame = 1'b1;
        rx_count = 0;
        rx_hits = 0;
      end
      return;
    end
    data_bytes++;
    if (rx_count >= BUFFER_DEPTH) begin
      rx_in_frame = 1'b0;
      rx_count = 0;
      rx_hits = 0;
      return;
    end
    rx_store[rx_count] = b;
    rx_count++;
    if (b == trailer_byte(rx_hits)) rx_hits++;
    else rx_hits = (b == END_BYTE0) ? 1 : 0;
    if (rx_hits < int'(END_LEN)) return;
    len = rx_count;
    rx_in_frame = 1'b0;
    rx_count = 0;
    rx_hits = 0;
    st = judge_frame(len);
    if (st != ST_OK) begin
      res = '{st, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
      fresh_results_q.push_back(res);
      return;
    end
    n = len - int'(END_LEN) - 1 - HEADER_LEN;
    if (n == 0) begin
      res = '{ST_OK, rx_store[7], rx_store[8], 8'h00, 1'b0, 1'b1};
      fresh_results_q.push_back(res);
      return;
    end
    for (int i = 0; i < n; i++) begin
      res = '{ST_OK, rx_store[7], rx_store[8], rx_store[HEADER_LEN + i], 1'b1,
              (i + 1 == n)};
      fresh_results_q.push_back(res);
    end
  endfunction

  function void post_results();
    while (fresh_results_q.size() != 0) begin
      frame_results_q.push_back(fresh_results_q.pop_front());
      results_posted++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{status_t'(out_if.status), out_if.mode, out_if.command,
              out_if.payload_byte, out_if.payload_valid, out_if.last};
      if (frame_results_q.size() == 0) begin
        note_failure({"unexpected word: ", show(got)});
      end else begin
        want = frame_results_q.pop_front();
        if (got !== want)
          note_failure({"mismatch: expected ", show(want), " got ", show(got)});
      end
    end
  end

  initial begin : sink_pacing
    int stall_left;
    int mode_left;
    bit steady;
    int r;
    stall_left = 0;
    mode_left = 0;
    steady = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      if (sink_hold > 0) begin
        sink_hold--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (!steady && r < 20)
          stall_left = (r < 17) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    absorb_rx_byte(b);
    if (!hold_results) post_results();
  endtask

  // Closes any open frame, then waits until the block has nothing left to say.
  task automatic settle();
    while (rx_in_frame) send_byte(trailer_byte(rx_hits));
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_PROTOCOL_ID: cfg_protocol = val;
      REG_DEVICE_ID:   cfg_device = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] data_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return START_BYTE;
      1:       return END_BYTE0;
      2:       return END_BYTE1;
      default: return END_BYTE2;
    endcase
  endfunction

  function automatic logic [7:0] lead_byte(input int i);
    case (i % 5)
      0:       return 8'hFF;
      1:       return 8'h00;
      2:       return END_BYTE0;
      3:       return END_BYTE1;
      default: return END_BYTE2;
    endcase
  endfunction

  function automatic void build_bytes(input stim_row_t r);
    logic [7:0] odd_bytes [9] = '{8'hFE, 8'hF1, 8'h1F, 8'h00, 8'hF1, 8'hF1, 8'h1F,
                                  8'hFE, 8'hFF};
    logic [7:0] sum;
    int         first;
    int         n;
    tx_bytes.delete();
    for (int i = 0; i < r.lead; i++) tx_bytes.push_back(lead_byte(i));
    tx_bytes.push_back(START_BYTE);
    first = tx_bytes.size();
    if (r.kind == ROW_FRAME || r.kind == ROW_TRICKY) begin
      tx_bytes.push_back(r.proto[15:8]);
      tx_bytes.push_back(r.proto[7:0]);
      tx_bytes.push_back(r.rsvd[15:8]);
      tx_bytes.push_back(r.rsvd[7:0]);
      tx_bytes.push_back(r.dev[15:8]);
      tx_bytes.push_back(r.dev[7:0]);
      tx_bytes.push_back(r.dir);
      tx_bytes.push_back(r.mode);
      tx_bytes.push_back(r.cmd);
    end
    n = (r.kind == ROW_TRICKY) ? 9 : r.npay;
    for (int i = 0; i < n; i++) begin
      if (r.kind == ROW_TRICKY) tx_bytes.push_back(odd_bytes[i]);
      else if (r.scramble) tx_bytes.push_back(data_byte());
      else tx_bytes.push_back(r.pbase + 8'(r.pstep * i));
    end
    if (r.kind == ROW_FRAME || r.kind == ROW_TRICKY) begin
      sum = 8'h00;
      for (int i = first; i < tx_bytes.size(); i++) sum = sum + tx_bytes[i];
      tx_bytes.push_back(sum + 8'(r.ckd));
    end
    if (r.kind != ROW_OPEN)
      for (int i = 0; i < 3; i++) tx_bytes.push_back(trailer_byte(i));
  endfunction

  task automatic run_row(input stim_row_t r);
    frame_result_t typed;
    if (r.kind == ROW_CFG) begin
      settle();
      write_reg(r.cfg_idx, r.cfg_val);
      return;
    end
    build_bytes(r);
    hold_results = (r.chk != CHK_MODEL);
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    hold_results = 1'b0;
    if (r.chk != CHK_MODEL) begin
      fresh_results_q.delete();
      if (r.chk == CHK_ONE) begin
        if (r.st == ST_OK) typed = '{ST_OK, r.mode, r.cmd, 8'h00, 1'b0, 1'b1};
        else typed = '{r.st, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
        fresh_results_q.push_back(typed);
      end
      post_results();
    end
  endtask

  function automatic stim_row_t good_row(input int n);
    stim_row_t r;
    r = '{ROW_FRAME, REG_PROTOCOL_ID, 16'h0000, cfg_protocol, RESERVED_WORD, cfg_device,
          DIR_DOWN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n,
          8'h00, 8'h00, 0, 0, 1'b1, CHK_MODEL, ST_OK};
    return r;
  endfunction

  function automatic int payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, BUFFER_DEPTH - MIN_LEN);
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    r = good_row(payload_len());
    if ($urandom_range(0, 99) < 15) r.lead = $urandom_range(1, 4);
    if (pick >= 70 && pick < 85) begin
      case ($urandom_range(0, 4))
        0:       r.proto = r.proto ^ (16'h0001 << $urandom_range(0, 15));
        1:       r.rsvd = 16'($urandom_range(1, 65535));
        2:       r.dev = r.dev ^ (16'h0001 << $urandom_range(0, 15));
        3:       r.dir = DIR_DOWN ^ 8'($urandom_range(1, 255));
        default: r.ckd = $urandom_range(1, 255);
      endcase
    end else if (pick >= 85 && pick < 92) begin
      r.kind = ROW_SHORT;
      r.npay = $urandom_range(0, MIN_LEN - 4);
    end else if (pick >= 92) begin
      r.kind = ROW_OPEN;
      r.npay = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 10)
                                           : $urandom_range(BUFFER_DEPTH + 1, BUFFER_DEPTH + 4);
    end
    return r;
  endfunction

  initial begin : stimulus
    int        bytes0;
    int        phase;
    int        mark;
    stim_row_t r;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = REG_PROTOCOL_ID;
    cfg_if.wdata = 16'h0000;
    for (int i = 0; i < BUFFER_DEPTH; i++) rx_store[i] = 8'h00;
    rx_count = 0;
    rx_in_frame = 1'b0;
    rx_hits = 0;
    cfg_protocol = 16'h0001;
    cfg_device = 16'h0001;
    hold_results = 1'b0;
    src_steady = 1'b0;
    sink_hold = 0;
    data_bytes = 0;
    results_posted = 0;
    fail_count = 0;

    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_ONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'hFF, 8'hFF, 0, 8'h00, 8'h00, 0, 5, 1'b0, CHK_ONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h12, 8'h34, 19, 8'h00, 8'h0D, 0, 0, 1'b0, CHK_MODEL, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'hA5, 8'h5A, 1, 8'hFF, 8'h00, 0, 0, 1'b0, CHK_MODEL, ST_OK});
    plan.push_back(stim_row_t'{ROW_TRICKY, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h01, 8'h02, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_MODEL, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0002, 16'h0000,
      16'h0001, DIR_DOWN, 8'h11, 8'h22, 2, 8'h40, 8'h01, 0, 0, 1'b0, CHK_ONE, ST_PROTOCOL});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0100,
      16'h0001, DIR_DOWN, 8'h11, 8'h22, 2, 8'h40, 8'h01, 0, 0, 1'b0, CHK_ONE, ST_RESERVED});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0000, DIR_DOWN, 8'h11, 8'h22, 2, 8'h40, 8'h01, 0, 0, 1'b0, CHK_ONE, ST_DEVICE});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_UP, 8'h11, 8'h22, 2, 8'h40, 8'h01, 0, 0, 1'b0, CHK_ONE, ST_DIRECTION});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h00, 8'h00, 2, 8'h10, 8'h01, 1, 0, 1'b0, CHK_ONE, ST_CHECKSUM});
    plan.push_back(stim_row_t'{ROW_SHORT, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_ONE, ST_SHORT});
    plan.push_back(stim_row_t'{ROW_SHORT, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h00, 8'h00, 9, 8'h00, 8'h00, 0, 0, 1'b0, CHK_ONE, ST_SHORT});
    plan.push_back(stim_row_t'{ROW_OPEN, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h00, 8'h00, 33, 8'h55, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'h0001, DIR_DOWN, 8'h33, 8'h44, 3, 8'h80, 8'h01, 0, 0, 1'b0, CHK_MODEL, ST_OK});
    plan.push_back(stim_row_t'{ROW_CFG, REG_PROTOCOL_ID, 16'h0000, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_CFG, REG_DEVICE_ID, 16'hFFFF, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_CFG, REG_SPARE_2, 16'h1234, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_CFG, REG_SPARE_3, 16'hABCD, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0000, 16'h0000,
      16'hFFFF, DIR_DOWN, 8'h7E, 8'h81, 2, 8'hF0, 8'h01, 0, 0, 1'b0, CHK_MODEL, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'h0001, 16'h0000,
      16'hFFFF, DIR_DOWN, 8'h7E, 8'h81, 2, 8'hF0, 8'h01, 0, 0, 1'b0, CHK_ONE, ST_PROTOCOL});
    plan.push_back(stim_row_t'{ROW_CFG, REG_PROTOCOL_ID, 16'hFFFF, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_CFG, REG_DEVICE_ID, 16'h0000, 16'h0, 16'h0, 16'h0,
      DIR_DOWN, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 1'b0, CHK_NONE, ST_OK});
    plan.push_back(stim_row_t'{ROW_FRAME, REG_PROTOCOL_ID, 16'h0, 16'hFFFF, 16'h0000,
      16'h0000, DIR_DOWN, 8'hC3, 8'h3C, 5, 8'h3C, 8'h11, 0, 0, 1'b0, CHK_MODEL, ST_OK});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) run_row(plan[i]);

    bytes0 = data_bytes;
    phase = 0;
    while (data_bytes - bytes0 < 100) begin
      settle();
      case (phase % 4)
        0: begin
          write_reg(REG_PROTOCOL_ID, 16'h0001);
          write_reg(REG_DEVICE_ID, 16'h0001);
        end
        2: begin
          write_reg(REG_PROTOCOL_ID, 16'h0000);
          write_reg(REG_DEVICE_ID, 16'hFFFF);
        end
        default: begin
          write_reg(REG_PROTOCOL_ID, 16'($urandom_range(0, 65535)));
          write_reg(REG_DEVICE_ID, 16'($urandom_range(0, 65535)));
        end
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_3, 16'($urandom_range(0, 65535)));
      src_steady = ($urandom_range(0, 2) == 0);
      if (phase == 1) begin
        // The sink holds ready low while good frames keep coming, so the queue fills up.
        sink_hold = HOLD_CYCLES;
        src_steady = 1'b1;
        repeat (4) run_row(good_row($urandom_range(2, 8)));
      end else begin
        mark = data_bytes;
        while (data_bytes - mark < 40) begin
          r = random_row();
          run_row(r);
        end
      end
      phase++;
    end

    settle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_if.sv
hw/rtl/scfr_store.sv
hw/rtl/scfr_jobq.sv
hw/rtl/scfr_front.sv
hw/rtl/scfr_back.sv
hw/rtl/serial_command_frame_receiver.sv
tb/sv/serial_command_frame_receiver_tb.sv
